// File: hdl/utf8bs_pkg.sv
// ----------------------------------------------------------------------------
// utf8bs_pkg
// Types, constants and decode helpers shared by the break segmenter modules.
// ----------------------------------------------------------------------------
package utf8bs_pkg;

	// segment kinds
	localparam logic [1:0] KIND_SPACE = 2'd0;
	localparam logic [1:0] KIND_CJK   = 2'd1;
	localparam logic [1:0] KIND_WORD  = 2'd2;
	localparam logic [1:0] KIND_EMPTY = 2'd3;

	localparam logic [15:0] LEN_MAX = 16'hFFFF;

	localparam logic [7:0] BYTE_TAB = 8'h09;
	localparam logic [7:0] BYTE_LF  = 8'h0A;
	localparam logic [7:0] BYTE_CR  = 8'h0D;
	localparam logic [7:0] BYTE_SP  = 8'h20;

	localparam logic [20:0] CP_BAD = 21'h00FFFD;

	localparam logic [20:0] CJK_A_LO = 21'h004E00;
	localparam logic [20:0] CJK_A_HI = 21'h009FFF;
	localparam logic [20:0] CJK_B_LO = 21'h003400;
	localparam logic [20:0] CJK_B_HI = 21'h004DBF;
	localparam logic [20:0] CJK_C_LO = 21'h020000;
	localparam logic [20:0] CJK_C_HI = 21'h02A6DF;
	localparam logic [20:0] CJK_D_LO = 21'h02A700;
	localparam logic [20:0] CJK_D_HI = 21'h02B73F;
	localparam logic [20:0] CJK_E_LO = 21'h00F900;
	localparam logic [20:0] CJK_E_HI = 21'h00FAFF;
	localparam logic [20:0] CJK_F_LO = 21'h003000;
	localparam logic [20:0] CJK_F_HI = 21'h00303F;
	localparam logic [20:0] CJK_G_LO = 21'h00FF00;
	localparam logic [20:0] CJK_G_HI = 21'h00FFEF;

	// result slots per item: byte phase, three tail bytes, closing segment
	localparam int NSLOT = 5;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       text_end;
	} item_t;

	typedef struct packed {
		logic        valid;
		logic        open;
		logic [1:0]  kind;
		logic [15:0] start;
		logic [15:0] length;
	} held_t;

	typedef struct packed {
		logic [23:0] char_bytes;
		logic [1:0]  char_count;
		logic [2:0]  char_needed;
		held_t       held;
	} state_t;

	typedef struct packed {
		logic [15:0] start;
		logic [15:0] length;
		logic [1:0]  kind;
		logic        brk;
		logic        last;
	} res_t;

	typedef struct packed {
		held_t h;
		logic  emit;
		res_t  r;
	} seg_ret_t;

	function automatic logic [2:0] lead_len(logic [7:0] b);
		logic [2:0] n;
		priority if (!b[7]) n = 3'd1;
		else if (b[7:5] == 3'b110) n = 3'd2;
		else if (b[7:4] == 4'b1110) n = 3'd3;
		else if (b[7:3] == 5'b11110) n = 3'd4;
		else n = 3'd1;
		return n;
	endfunction

	function automatic logic [20:0] cp_of(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
		logic [7:0] b3, logic [2:0] n);
		logic [20:0] cp;
		unique case (n)
			3'd1: cp = b0[7] ? CP_BAD : 21'(b0);
			3'd2: cp = 21'({b0[4:0], b1[5:0]});
			3'd3: cp = 21'({b0[3:0], b1[5:0], b2[5:0]});
			default: cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
		endcase
		return cp;
	endfunction

	function automatic logic in_cjk(logic [20:0] cp);
		return (cp >= CJK_A_LO && cp <= CJK_A_HI) ||
			(cp >= CJK_B_LO && cp <= CJK_B_HI) ||
			(cp >= CJK_C_LO && cp <= CJK_C_HI) ||
			(cp >= CJK_D_LO && cp <= CJK_D_HI) ||
			(cp >= CJK_E_LO && cp <= CJK_E_HI) ||
			(cp >= CJK_F_LO && cp <= CJK_F_HI) ||
			(cp >= CJK_G_LO && cp <= CJK_G_HI);
	endfunction

	// grow the held segment or flush it and start a new one
	function automatic seg_ret_t take_seg(held_t h, logic [1:0] kind, logic [15:0] start,
		logic [2:0] n);
		seg_ret_t   r;
		logic [16:0] sum;
		r      = '0;
		r.h    = h;
		sum    = {1'b0, h.length} + 17'(n);
		if (kind != KIND_CJK && h.valid && h.open && h.kind == kind) begin
			r.h.length = sum[16] ? LEN_MAX : sum[15:0];
		end else begin
			r.emit     = h.valid;
			r.r.start  = h.start;
			r.r.length = h.length;
			r.r.kind   = h.kind;
			r.r.brk    = !(h.kind == KIND_WORD && kind == KIND_WORD);
			r.r.last   = 1'b0;
			r.h.valid  = 1'b1;
			r.h.kind   = kind;
			r.h.start  = start;
			r.h.length = 16'(n);
			r.h.open   = (kind != KIND_CJK);
		end
		return r;
	endfunction

	// one byte standing alone: space, line end, or a one-byte word character
	function automatic seg_ret_t take_single(held_t h, logic [7:0] c, logic [15:0] start);
		seg_ret_t r;
		r   = '0;
		r.h = h;
		priority if (c == BYTE_SP || c == BYTE_TAB) r = take_seg(h, KIND_SPACE, start, 3'd1);
		else if (c == BYTE_LF || c == BYTE_CR) r.h.open = 1'b0;
		else r = take_seg(h, KIND_WORD, start, 3'd1);
		return r;
	endfunction

endpackage

// File: hdl/utf8_break_segmenter.sv
// ----------------------------------------------------------------------------
// utf8_break_segmenter
// Splits UTF-8 text into line break segments: space runs, CJK characters,
// and words, each with start offset, length and break flag.
// ----------------------------------------------------------------------------
// Usage: the byte channel (byte_valid/byte_stall) carries one item per
// transfer: data_byte with has_byte, and text_end to close the text. The
// segment channel (seg_valid/seg_stall) returns segment descriptors.
// A word is held back until the following segment is known, so a segment
// usually appears one or more bytes after its last byte; the closing item
// of a text flushes everything and its last result has last_segment set.
// An accepted item is held in the input register and then loaded into the
// result register, from which its results are taken; while the result
// register has no room, the item waits in the input register.
// Throughput: one item per cycle while each item gives at most one result
// and the receiver does not stall. An item that gives k results holds the
// result register for k transfers; the closing item can give up to four.
// The result register's drain sets the rate: a new item enters it only as
// its last pending result leaves. When the receiver stalls, the result on
// the port holds, and once the input register is full byte_stall rises.
// Reset clears all text state: the next byte starts a text at offset 0.
// ----------------------------------------------------------------------------
module utf8_break_segmenter #(
	parameter int POS_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        text_end,
	output logic        seg_valid,
	input  logic        seg_stall,
	output logic [15:0] seg_start,
	output logic [15:0] seg_length,
	output logic [1:0]  seg_kind,
	output logic        break_after,
	output logic        last_segment
);
	import utf8bs_pkg::*;

	logic                valid_s1;
	item_t               item_s1;
	logic [POS_BITS-1:0] pos_q;
	state_t              st_q;
	logic [POS_BITS-1:0] pos_nx;
	state_t              st_nx;
	res_t [NSLOT-1:0]    res;
	logic [NSLOT-1:0]    res_valid;
	logic                room;
	logic                advance;

	assign advance    = valid_s1 && room;
	assign byte_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			item_s1.data_byte <= data_byte;
			item_s1.has_byte  <= has_byte;
			item_s1.text_end  <= text_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			st_q  <= '0;
		end else if (advance) begin
			pos_q <= pos_nx;
			st_q  <= st_nx;
		end
	end

	utf8bs_step #(
		.POS_BITS(POS_BITS)
	) u_step (
		.item      (item_s1),
		.pos       (pos_q),
		.st        (st_q),
		.pos_nx    (pos_nx),
		.st_nx     (st_nx),
		.res       (res),
		.res_valid (res_valid)
	);

	utf8bs_outq u_outq (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (advance),
		.res          (res),
		.res_valid    (res_valid),
		.room         (room),
		.seg_valid    (seg_valid),
		.seg_stall    (seg_stall),
		.seg_start    (seg_start),
		.seg_length   (seg_length),
		.seg_kind     (seg_kind),
		.break_after  (break_after),
		.last_segment (last_segment)
	);

	// closing item leaves clean state behind
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.text_end |=> pos_q == '0 && st_q.char_count == 2'd0 &&
		!st_q.held.valid)
		else $error("text state not cleared after end of text");

	// closing item always produces at least the final segment
	a_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.text_end |=> seg_valid)
		else $error("no result after end of text");

	// a partial character always still needs more bytes
	a_char_open: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.char_count != 2'd0 |-> st_q.char_needed > {1'b0, st_q.char_count})
		else $error("partial character count out of range");

	// stall toward the sender only with a held item
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> valid_s1 && seg_valid)
		else $error("input stalled with empty pipeline");

endmodule

// File: hdl/utf8bs_step.sv
// ----------------------------------------------------------------------------
// utf8bs_step
// Next-state and result logic for one item: byte decode, tail replay at the
// end of a text, and the closing segment.
// ----------------------------------------------------------------------------
module utf8bs_step #(
	parameter int POS_BITS = 16
) (
	input  utf8bs_pkg::item_t                         item,
	input  logic [POS_BITS-1:0]                       pos,
	input  utf8bs_pkg::state_t                        st,
	output logic [POS_BITS-1:0]                       pos_nx,
	output utf8bs_pkg::state_t                        st_nx,
	output utf8bs_pkg::res_t [utf8bs_pkg::NSLOT-1:0]  res,
	output logic [utf8bs_pkg::NSLOT-1:0]              res_valid
);
	import utf8bs_pkg::*;

	always_comb begin
		state_t              s;
		held_t               h;
		seg_ret_t            sr;
		logic [7:0]          b;
		logic [7:0]          arr [4];
		logic [7:0]          tb [3];
		logic [2:0]          need;
		logic [20:0]         cp;
		logic [POS_BITS-1:0] base;
		logic [POS_BITS-1:0] char_pos;
		logic                skip2;

		s         = st;
		h         = st.held;
		sr        = '0;
		base      = '0;
		tb[0]     = '0;
		tb[1]     = '0;
		tb[2]     = '0;
		pos_nx    = pos;
		res       = '0;
		res_valid = '0;
		b         = item.data_byte;
		need      = lead_len(b);
		skip2     = 1'b0;
		arr[0]    = st.char_bytes[7:0];
		arr[1]    = st.char_bytes[15:8];
		arr[2]    = st.char_bytes[23:16];
		arr[3]    = 8'h00;
		arr[st.char_count] = b;
		cp        = cp_of(arr[0], arr[1], arr[2], arr[3], st.char_needed);
		char_pos  = pos - POS_BITS'(st.char_count);

		if (item.has_byte) begin
			pos_nx = pos + POS_BITS'(1);
			if (st.char_count == 2'd0) begin
				if (need == 3'd1) begin
					sr           = take_single(h, b, 16'(pos));
					h            = sr.h;
					res[0]       = sr.r;
					res_valid[0] = sr.emit;
				end else begin
					s.char_bytes  = 24'(b);
					s.char_count  = 2'd1;
					s.char_needed = need;
				end
			end else if ({1'b0, st.char_count} + 3'd1 >= st.char_needed) begin
				// character complete
				sr            = take_seg(h, in_cjk(cp) ? KIND_CJK : KIND_WORD, 16'(char_pos),
					st.char_needed);
				h             = sr.h;
				res[0]        = sr.r;
				res_valid[0]  = sr.emit;
				s.char_bytes  = '0;
				s.char_count  = '0;
				s.char_needed = '0;
			end else begin
				s.char_bytes = st.char_bytes | (24'(b) << {st.char_count, 3'b000});
				s.char_count = st.char_count + 2'd1;
			end
		end

		if (item.text_end) begin
			// a cut-short character is decoded again byte by byte
			base  = pos_nx - POS_BITS'(s.char_count);
			tb[0] = s.char_bytes[7:0];
			tb[1] = s.char_bytes[15:8];
			tb[2] = s.char_bytes[23:16];
			if (s.char_count != 2'd0) begin
				sr           = take_single(h, tb[0], 16'(base));
				h            = sr.h;
				res[1]       = sr.r;
				res_valid[1] = sr.emit;
			end
			if (s.char_count >= 2'd2) begin
				if (s.char_count == 2'd3 && lead_len(tb[1]) == 3'd2) begin
					// two-byte character fits in the tail, never cjk
					sr    = take_seg(h, KIND_WORD, 16'(base + POS_BITS'(1)), 3'd2);
					skip2 = 1'b1;
				end else begin
					sr = take_single(h, tb[1], 16'(base + POS_BITS'(1)));
				end
				h            = sr.h;
				res[2]       = sr.r;
				res_valid[2] = sr.emit;
			end
			if (s.char_count == 2'd3 && !skip2) begin
				sr           = take_single(h, tb[2], 16'(base + POS_BITS'(2)));
				h            = sr.h;
				res[3]       = sr.r;
				res_valid[3] = sr.emit;
			end
			if (h.valid) begin
				res[4].start  = h.start;
				res[4].length = h.length;
				res[4].kind   = h.kind;
				res[4].brk    = 1'b1;
			end else begin
				res[4].start  = '0;
				res[4].length = '0;
				res[4].kind   = KIND_EMPTY;
				res[4].brk    = 1'b0;
			end
			res[4].last  = 1'b1;
			res_valid[4] = 1'b1;
			s            = '0;
			h            = '0;
			pos_nx       = '0;
		end

		st_nx      = s;
		st_nx.held = h;
	end

endmodule

// File: hdl/utf8bs_outq.sv
// ----------------------------------------------------------------------------
// utf8bs_outq
// Result register: holds the segments of one item and hands them out one
// per accepted transfer, in order.
// ----------------------------------------------------------------------------
module utf8bs_outq (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      load,
	input  utf8bs_pkg::res_t [utf8bs_pkg::NSLOT-1:0]  res,
	input  logic [utf8bs_pkg::NSLOT-1:0]              res_valid,
	output logic                                      room,
	output logic                                      seg_valid,
	input  logic                                      seg_stall,
	output logic [15:0]                               seg_start,
	output logic [15:0]                               seg_length,
	output logic [1:0]                                seg_kind,
	output logic                                      break_after,
	output logic                                      last_segment
);
	import utf8bs_pkg::*;

	res_t [NSLOT-1:0] slot_q;
	logic [NSLOT-1:0] mask_q;
	logic [NSLOT-1:0] sel;
	logic [NSLOT-1:0] mask_nx;
	logic             pop;
	res_t             pick;

	// lowest pending slot goes out first
	assign sel = mask_q & (~mask_q + NSLOT'(1));

	always_comb begin
		pick = '0;
		for (int i = 0; i < NSLOT; i++) begin
			if (sel[i]) pick = res_t'(pick | slot_q[i]);
		end
	end

	assign seg_valid = |mask_q;
	assign pop       = seg_valid && !seg_stall;
	assign mask_nx   = pop ? (mask_q & ~sel) : mask_q;
	assign room      = (mask_nx == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else begin
			mask_q <= load ? res_valid : mask_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot_q <= res;
		end
	end

	assign seg_start    = pick.start;
	assign seg_length   = pick.length;
	assign seg_kind     = pick.kind;
	assign break_after  = pick.brk;
	assign last_segment = pick.last;

endmodule
